// ===== rtl/scds_pkg.sv =====
`timescale 1ns / 1ps

package scds_pkg;

   // Field widths of the stream payloads
   localparam int RATE_W     = 32;
   localparam int PRESCALE_W = 3;
   localparam int DIVIDER_W  = 8;
   localparam int RSP_DATA_W = 16;

   // Divider sits at divide-by-(code + 2)
   localparam int DIVISOR_OFFSET = 2;

   // Defaults for the search space and the clock register
   localparam int DEF_PRESCALE_STEPS = 8;
   localparam int DEF_DIVIDER_STEPS  = 256;
   localparam logic [RATE_W-1:0] RESET_CLOCK_HZ = 32'd12000000;

endpackage

// ===== rtl/serial_clock_divider_search.sv =====
// Serial clock divider search. A request beat carries a wanted serial clock rate in hertz;
// the block answers with one response beat giving the power-of-two prescale exponent and the
// divider code (divisor = code + 2) whose rate, source clock / (2^prescale * (code + 2)) rounded
// down, is closest to the request without exceeding it. Candidates are tried prescale-major,
// divider ascending; the first strictly closer one is kept and the search stops on an exact
// match. When nothing fits, the answer is the largest prescale and divider. A request of zero
// returns at once with the invalid flag set in rsp_tuser and both fields zero. The source clock
// is a single register written over the csr_ channel (reset value 12 MHz); write it only while
// no request is outstanding. A nonzero request ends its search early on an exact match; a zero
// request skips the search. Every candidate goes through the one shared restoring divider,
// which produces one quotient bit per cycle, followed by a compare against the best
// candidate. The block takes no new request while a search runs, but does take one while the
// previous response still waits on rsp_tready.
`timescale 1ns / 1ps

module serial_clock_divider_search
   import scds_pkg::*;
#(
   parameter int PRESCALE_STEPS = DEF_PRESCALE_STEPS,
   parameter int DIVIDER_STEPS  = DEF_DIVIDER_STEPS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [RATE_W-1:0]     req_tdata,   // [31:0] requested_rate_hz
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] prescale_exponent, [10:3] divider_code,
                                              // [15:11] zero
   output logic                  rsp_tuser,   // [0] invalid_rate
   // source clock register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RATE_W-1:0]     csr_data     // source_clock_hz
);

   localparam int P_W   = (PRESCALE_STEPS > 1) ? $clog2(PRESCALE_STEPS) : 1;
   localparam int S_W   = $clog2(DIVIDER_STEPS);
   localparam int D_W   = $clog2(DIVIDER_STEPS + DIVISOR_OFFSET);
   localparam int CNT_W = $clog2(RATE_W);

   localparam logic [P_W-1:0]   P_LAST   = P_W'(PRESCALE_STEPS - 1);
   localparam logic [S_W-1:0]   S_LAST   = S_W'(DIVIDER_STEPS - 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RATE_W - 1);

   typedef enum logic [1:0] {
      IDLE_ST,
      DIVIDE_ST,
      EVAL_ST,
      EMIT_ST
   } state_type;

   state_type               state_ff, state_in;
   logic [RATE_W-1:0]       clk_hz_ff, clk_hz_in;
   logic [RATE_W-1:0]       rate_ff, rate_in;
   logic [P_W-1:0]          p_ff, p_in;
   logic [S_W-1:0]          s_ff, s_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [D_W-1:0]          rem_ff, rem_in;
   logic [RATE_W-1:0]       quo_ff, quo_in;
   logic [P_W-1:0]          best_p_ff, best_p_in;
   logic [S_W-1:0]          best_s_ff, best_s_in;
   logic [RATE_W-1:0]       best_diff_ff, best_diff_in;
   logic                    invalid_ff, invalid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;

   // shared divider datapath
   logic [D_W-1:0]          divisor;
   logic [D_W:0]            trial;
   logic                    trial_fits;
   logic [D_W:0]            trial_sub;
   // candidate evaluation
   logic                    cand_fits;
   logic [RATE_W-1:0]       cand_diff;
   logic                    cand_better;
   logic                    slot_free;

   assign divisor    = D_W'(s_ff) + D_W'(DIVISOR_OFFSET);
   assign trial      = {rem_ff, quo_ff[RATE_W-1]};
   assign trial_fits = trial >= {1'b0, divisor};
   assign trial_sub  = trial - {1'b0, divisor};

   assign cand_fits   = quo_ff <= rate_ff;
   assign cand_diff   = rate_ff - quo_ff;
   assign cand_better = cand_fits && (cand_diff < best_diff_ff);

   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == IDLE_ST);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      clk_hz_in    = clk_hz_ff;
      rate_in      = rate_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      best_p_in    = best_p_ff;
      best_s_in    = best_s_ff;
      best_diff_in = best_diff_ff;
      invalid_in   = invalid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         clk_hz_in = csr_data;
      end

      unique case (state_ff)
         IDLE_ST: begin
            if (req_tvalid) begin
               rate_in      = req_tdata;
               p_in         = '0;
               s_in         = '0;
               cnt_in       = '0;
               rem_in       = '0;
               quo_in       = clk_hz_ff;
               best_diff_in = '1;
               if (req_tdata == '0) begin
                  // zero rate: flag it and skip the search
                  invalid_in = 1'b1;
                  best_p_in  = '0;
                  best_s_in  = '0;
                  state_in   = EMIT_ST;
               end else begin
                  invalid_in = 1'b0;
                  best_p_in  = P_LAST;
                  best_s_in  = S_LAST;
                  state_in   = DIVIDE_ST;
               end
            end
         end

         DIVIDE_ST: begin
            // one restoring step: shift in a dividend bit, subtract if it fits
            if (trial_fits) begin
               rem_in = trial_sub[D_W-1:0];
            end else begin
               rem_in = trial[D_W-1:0];
            end
            quo_in = {quo_ff[RATE_W-2:0], trial_fits};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = EVAL_ST;
            end
         end

         EVAL_ST: begin
            if (cand_better) begin
               best_diff_in = cand_diff;
               best_p_in    = p_ff;
               best_s_in    = s_ff;
            end
            if (cand_better && (cand_diff == '0)) begin
               state_in = EMIT_ST;
            end else if (s_ff == S_LAST && p_ff == P_LAST) begin
               state_in = EMIT_ST;
            end else begin
               // advance divider first, then prescale
               if (s_ff == S_LAST) begin
                  s_in = '0;
                  p_in = p_ff + P_W'(1);
               end else begin
                  s_in = s_ff + S_W'(1);
               end
               // clk / (2^p * d) == (clk >> p) / d
               quo_in   = clk_hz_ff >> p_in;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = DIVIDE_ST;
            end
         end

         EMIT_ST: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({DIVIDER_W'(best_s_ff), PRESCALE_W'(best_p_ff)});
               rsp_user_in  = invalid_ff;
               state_in     = IDLE_ST;
            end
         end

         default: begin
            state_in = IDLE_ST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_ST;
         clk_hz_ff    <= RESET_CLOCK_HZ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_hz_ff    <= clk_hz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rate_ff      <= rate_in;
      p_ff         <= p_in;
      s_ff         <= s_in;
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      best_p_ff    <= best_p_in;
      best_s_ff    <= best_s_in;
      best_diff_ff <= best_diff_in;
      invalid_ff   <= invalid_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   // The partial remainder always stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIVIDE_ST) |-> (rem_ff < divisor))
      else $error("divider remainder not below divisor");

   // A division runs its full count before evaluation
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIVIDE_ST && cnt_ff != CNT_LAST) |=> (state_ff == DIVIDE_ST))
      else $error("division left early");

   // The best difference never grows during a search
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == EVAL_ST) |=> (best_diff_ff <= $past(best_diff_ff)))
      else $error("best difference increased");

   // An invalid-rate response carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (rsp_data_ff == '0))
      else $error("invalid response with nonzero fields");

endmodule

// ===== tb/serial_clock_divider_search_tb.sv =====
`timescale 1ns / 1ps

module serial_clock_divider_search_tb;
   import scds_pkg::*;

   localparam int PRESCALE_STEPS  = DEF_PRESCALE_STEPS;
   localparam int DIVIDER_STEPS   = DEF_DIVIDER_STEPS;
   // worst-case search: one division plus one compare per candidate
   localparam int SEARCH_CYCLES   = PRESCALE_STEPS * DIVIDER_STEPS * 33 + 2;
   localparam int IDLE_PCT        = 22;
   localparam int NUM_DIRECTED    = 20;
   localparam int NUM_PHASES      = 5;
   localparam int ITEMS_PER_PHASE = 17;
   localparam int TAIL_CYCLES     = 100;
   // every beat a full search, stalls included, taken four times over
   localparam longint CYCLE_LIMIT =
      longint'(NUM_DIRECTED + NUM_PHASES * ITEMS_PER_PHASE) * SEARCH_CYCLES * 4;

   typedef struct packed {
      logic [PRESCALE_W-1:0] prescale;
      logic [DIVIDER_W-1:0]  divider;
      logic                  invalid;
   } divider_choice_type;

   typedef struct packed {
      logic                  set_clock;   // write the source clock before this beat
      logic [RATE_W-1:0]     clock_hz;
      logic [RATE_W-1:0]     rate_hz;
      logic                  known;       // answer typed in below
      divider_choice_type    want;
   } directed_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RATE_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [RATE_W-1:0]     csr_data   = '0;

   divider_choice_type pending_choices[$];
   logic [RATE_W-1:0] source_hz = RESET_CLOCK_HZ;   // our copy of the clock register
   logic              steady    = 1'b0;             // suppress idling on both sides
   longint            cycles    = 0;
   int                mismatches = 0;
   int                n_items = 0, n_zero = 0, n_exact = 0, n_checked = 0, n_clock_writes = 0;

   serial_clock_divider_search #(
      .PRESCALE_STEPS(PRESCALE_STEPS),
      .DIVIDER_STEPS (DIVIDER_STEPS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scan prescale-major, divider ascending; keep only a strictly smaller
   // shortfall below the request and stop at the first exact hit. Nothing
   // fitting leaves the slowest setting in place.
   function automatic divider_choice_type search_divider(input logic [RATE_W-1:0] src_hz,
                                                         input logic [RATE_W-1:0] rate_hz);
      divider_choice_type best;
      logic [RATE_W-1:0]  best_gap;
      logic [RATE_W-1:0]  gap;
      logic [63:0]        divisor;
      logic [63:0]        actual;
      bit                 hit;
      best     = '{prescale: PRESCALE_W'(PRESCALE_STEPS - 1),
                   divider:  DIVIDER_W'(DIVIDER_STEPS - 1),
                   invalid:  1'b0};
      best_gap = '1;
      hit      = 1'b0;
      if (rate_hz == '0)
         return '{prescale: '0, divider: '0, invalid: 1'b1};
      for (int p = 0; p < PRESCALE_STEPS && !hit; p++) begin
         for (int s = 0; s < DIVIDER_STEPS && !hit; s++) begin
            divisor = 64'(s + DIVISOR_OFFSET) << p;
            actual  = {32'd0, src_hz} / divisor;
            if (actual <= {32'd0, rate_hz}) begin
               gap = rate_hz - actual[RATE_W-1:0];
               if (gap < best_gap) begin
                  best_gap      = gap;
                  best.prescale = PRESCALE_W'(p);
                  best.divider  = DIVIDER_W'(s);
                  hit           = (gap == '0);
               end
            end
         end
      end
      return best;
   endfunction

   task automatic flag_mismatch(input string what, input logic [RATE_W-1:0] got,
                                input logic [RATE_W-1:0] want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Hold until every outstanding response has come back. Entered and left
   // at a falling edge.
   task automatic wait_drained();
      while (pending_choices.size() != 0)
         @(negedge clock);
   endtask

   // Write the source clock register, only once the block is idle.
   task automatic write_source_clock(input logic [RATE_W-1:0] hz);
      wait_drained();
      csr_valid = 1'b1;
      csr_data  = hz;
      do @(posedge clock); while (!csr_ready);
      source_hz = hz;
      n_clock_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Offer one request beat, with random idle cycles ahead of it, and queue
   // its expected answer at the handshake.
   task automatic send_rate(input logic [RATE_W-1:0] rate_hz, input divider_choice_type want);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = rate_hz;
      do @(posedge clock); while (!req_tready);
      pending_choices.push_back(want);
      n_items++;
      if (rate_hz == '0)
         n_zero++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Stall the response side at random, except through the steady stretch.
   always @(negedge clock)
      rsp_tready = steady || ($urandom_range(0, 99) >= IDLE_PCT);

   // Compare every response beat with the oldest expectation.
   always @(posedge clock) begin
      divider_choice_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_choices.size() == 0) begin
            flag_mismatch("response with nothing outstanding", 32'(rsp_tdata), '0);
         end else begin
            want = pending_choices.pop_front();
            n_checked++;
            if (rsp_tdata[PRESCALE_W-1:0] != want.prescale)
               flag_mismatch("prescale_exponent", 32'(rsp_tdata[PRESCALE_W-1:0]),
                             32'(want.prescale));
            if (rsp_tdata[PRESCALE_W +: DIVIDER_W] != want.divider)
               flag_mismatch("divider_code", 32'(rsp_tdata[PRESCALE_W +: DIVIDER_W]),
                             32'(want.divider));
            if (rsp_tdata[RSP_DATA_W-1:PRESCALE_W+DIVIDER_W] != '0)
               flag_mismatch("tdata padding", 32'(rsp_tdata[RSP_DATA_W-1:PRESCALE_W+DIVIDER_W]),
                             '0);
            if (rsp_tuser != want.invalid)
               flag_mismatch("invalid_rate", 32'(rsp_tuser), 32'(want.invalid));
         end
      end
   end

   // Watchdog: give up well past the slowest correct run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, pending_choices.size());
         $display("serial_clock_divider_search_tb NOT OK");
         $finish;
      end
   end

   // Directed table: field extremes, the fallback to the slowest setting,
   // the all-ones shortfall that is never taken, zero rate and zero clock.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // reset clock of 12 MHz
      '{1'b0, 32'd0,          32'd0,          1'b1, '{3'd0, 8'd0,   1'b1}},
      '{1'b0, 32'd0,          32'd6000000,    1'b1, '{3'd0, 8'd0,   1'b0}},
      '{1'b0, 32'd0,          32'hFFFFFFFF,   1'b1, '{3'd0, 8'd0,   1'b0}},
      '{1'b0, 32'd0,          32'd1,          1'b1, '{3'd7, 8'd255, 1'b0}},
      '{1'b0, 32'd0,          32'd300000,     1'b0, '{3'd0, 8'd0,   1'b0}},
      '{1'b0, 32'd0,          32'd5999999,    1'b0, '{3'd0, 8'd0,   1'b0}},
      '{1'b0, 32'd0,          32'h80000000,   1'b0, '{3'd0, 8'd0,   1'b0}},
      '{1'b0, 32'd0,          32'd46875,      1'b0, '{3'd0, 8'd0,   1'b0}},
      // fastest source clock
      '{1'b1, 32'hFFFFFFFF,   32'hFFFFFFFF,   1'b0, '{3'd0, 8'd0,   1'b0}},
      '{1'b0, 32'd0,          32'd1,          1'b1, '{3'd7, 8'd255, 1'b0}},
      '{1'b0, 32'd0,          32'h55555555,   1'b0, '{3'd0, 8'd0,   1'b0}},
      // 1 Hz clock: every candidate rate is zero
      '{1'b1, 32'd1,          32'd1,          1'b1, '{3'd0, 8'd0,   1'b0}},
      '{1'b0, 32'd0,          32'hFFFFFFFF,   1'b1, '{3'd7, 8'd255, 1'b0}},
      // zero clock: every candidate rate is zero
      '{1'b1, 32'd0,          32'd5,          1'b1, '{3'd0, 8'd0,   1'b0}},
      '{1'b0, 32'd0,          32'hFFFFFFFF,   1'b1, '{3'd7, 8'd255, 1'b0}},
      '{1'b0, 32'd0,          32'd0,          1'b1, '{3'd0, 8'd0,   1'b1}},
      // exact on the very first candidate
      '{1'b1, 32'd2,          32'd1,          1'b1, '{3'd0, 8'd0,   1'b0}},
      '{1'b1, 32'hAAAAAAAA,   32'h00ABCDEF,   1'b0, '{3'd0, 8'd0,   1'b0}},
      '{1'b1, 32'd100000000,  32'd390625,     1'b0, '{3'd0, 8'd0,   1'b0}},
      '{1'b0, 32'd0,          32'h7FFFFFFF,   1'b0, '{3'd0, 8'd0,   1'b0}}
   };

   initial begin
      logic [RATE_W-1:0] hz;
      logic [RATE_W-1:0] rate_hz;
      logic [63:0]       cand;
      int unsigned       pick;
      int unsigned       p;
      int unsigned       s;

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed part, starting from the reset clock value.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_clock)
            write_source_clock(directed_rows[i].clock_hz);
         send_rate(directed_rows[i].rate_hz,
                   directed_rows[i].known ? directed_rows[i].want
                                          : search_divider(source_hz, directed_rows[i].rate_hz));
      end

      // Random part in phases, one source clock setting per phase. Most beats
      // ask for a rate that some candidate hits exactly, so the search ends
      // early; the rest land just off a candidate, are zero or are arbitrary.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       hz = RESET_CLOCK_HZ;
            1:       hz = $urandom;
            2:       hz = $urandom_range(1, 1000);
            3:       hz = '1;
            default: hz = $urandom_range(1_000_000, 200_000_000);
         endcase
         write_source_clock(hz);
         steady = (phase == 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // let the pipe run dry once mid-phase before the next beat
            if (phase == 3 && n == ITEMS_PER_PHASE / 2)
               wait_drained();
            pick = $urandom_range(0, 99);
            p    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PRESCALE_STEPS - 1)
                                               : $urandom_range(0, 1);
            s    = $urandom_range(0, DIVIDER_STEPS - 1);
            cand = {32'd0, source_hz} / (64'(s + DIVISOR_OFFSET) << p);
            if (pick < 70) begin
               rate_hz = cand[RATE_W-1:0];
               if (cand != '0)
                  n_exact++;
            end else if (pick < 76) begin
               rate_hz = cand[RATE_W-1:0] + RATE_W'($urandom_range(1, 3));
            end else if (pick < 84) begin
               rate_hz = '0;
            end else if (pick < 93) begin
               rate_hz = $urandom;
            end else begin
               rate_hz = $urandom_range(1, 1000);
            end
            send_rate(rate_hz, search_divider(source_hz, rate_hz));
         end
      end
      steady = 1'b0;

      // Drain, then watch a little longer for any stray response.
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("sent %0d rate requests (%0d zero, %0d on an exact candidate rate)",
               n_items, n_zero, n_exact);
      $display("over %0d source clock writes; %0d responses checked, %0d mismatches",
               n_clock_writes, n_checked, mismatches);
      if (mismatches == 0 && pending_choices.size() == 0) begin
         $display("serial_clock_divider_search_tb OK");
      end else begin
         $display("serial_clock_divider_search_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== serial_clock_divider_search.f =====
rtl/scds_pkg.sv
rtl/serial_clock_divider_search.sv
tb/serial_clock_divider_search_tb.sv
